@@ design/dnle_pkg.sv @@
// Shared types and constants for the DNS name label encoder.
`timescale 1ns / 1ps

package dnle_pkg;

    // Default label bound and the store depth that follows from it
    localparam int LABEL_MAX_DEF = 62;

    // Character codes and the zone marker
    localparam logic [7:0] CHAR_END  = 8'h00;
    localparam logic [7:0] CHAR_DOT  = 8'h2E;
    localparam logic [7:0] ZONE_MARK = 8'hC0;

    // Controller states
    typedef enum logic [2:0] {
        ST_ACCEPT,
        ST_LEN,
        ST_RD,
        ST_CHR,
        ST_TERM
    } dnle_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic store_char;  // write an accepted label character
        logic take_delim;  // latch the kind of an accepted delimiter
        logic load_len;    // put the length byte or zone marker into the output word
        logic rd_issue;    // read the store at the read pointer
        logic load_chr;    // put the read character into the output word
        logic load_term;   // put the zero terminator into the output word
        logic clear;       // start a new label
    } dnle_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic in_delim;    // input word is a dot or the terminator
        logic count_zero;  // label holds no character
        logic at_end;      // label being flushed ends the name
        logic rd_last;     // read pointer is at the last stored character
        logic out_free;    // output register can take a word this cycle
    } dnle_status_t;

endpackage

@@ design/dnle_ctrl.sv @@
// Controller state machine of the DNS name label encoder.
`timescale 1ns / 1ps

module dnle_ctrl
    import dnle_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  dnle_status_t status,
    output dnle_cmd_t    cmd
);

    dnle_state_t state_reg;
    dnle_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACCEPT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_ACCEPT:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (status.in_delim)
                    begin
                        cmd.take_delim = 1'b1;
                        state_next     = ST_LEN;
                    end
                    else
                    begin
                        cmd.store_char = 1'b1;
                    end
                end
            end
            ST_LEN:
            begin
                if (status.out_free)
                begin
                    cmd.load_len = 1'b1;
                    if (!status.count_zero)
                    begin
                        state_next = ST_RD;
                    end
                    else if (status.at_end)
                    begin
                        state_next = ST_TERM;
                    end
                    else
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_ACCEPT;
                    end
                end
            end
            ST_RD:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_CHR;
            end
            ST_CHR:
            begin
                if (status.out_free)
                begin
                    cmd.load_chr = 1'b1;
                    if (!status.rd_last)
                    begin
                        state_next = ST_RD;
                    end
                    else if (status.at_end)
                    begin
                        state_next = ST_TERM;
                    end
                    else
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_ACCEPT;
                    end
                end
            end
            ST_TERM:
            begin
                if (status.out_free)
                begin
                    cmd.load_term = 1'b1;
                    cmd.clear     = 1'b1;
                    state_next    = ST_ACCEPT;
                end
            end
            default:
            begin
                state_next = ST_ACCEPT;
            end
        endcase
    end

endmodule

@@ design/dnle_dp.sv @@
// Datapath of the DNS name label encoder: label store, counters and output register.
`timescale 1ns / 1ps

module dnle_dp
    import dnle_pkg::*;
#(
    parameter int LABEL_MAX = LABEL_MAX_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic [7:0]   in_char,
    input  dnle_cmd_t    cmd,
    output dnle_status_t status,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [7:0]   out_byte,
    output logic         out_ovf,
    output logic         out_last
);

    localparam int CntW = $clog2(LABEL_MAX + 1);
    localparam int IdxW = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;
    localparam logic [CntW-1:0] CountMax = CntW'(LABEL_MAX);

    // Label store, contents undefined until written
    logic [7:0] store_mem [LABEL_MAX];

    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    logic            ovf_reg;
    logic            ovf_next;
    logic            end_reg;
    logic            end_next;
    logic [CntW-1:0] rd_idx_reg;
    logic [CntW-1:0] rd_idx_next;
    logic [7:0]      rd_data_reg;

    logic            out_valid_reg;
    logic            out_valid_next;
    logic [7:0]      out_byte_reg;
    logic [7:0]      out_byte_next;
    logic            out_ovf_reg;
    logic            out_ovf_next;
    logic            out_last_reg;
    logic            out_last_next;

    logic            room;
    logic [7:0]      len_byte;

    assign room     = (count_reg < CountMax);
    assign len_byte = {{(8 - CntW){1'b0}}, count_reg};

    // Status towards the controller
    assign status.in_delim   = (in_char == CHAR_DOT) || (in_char == CHAR_END);
    assign status.count_zero = (count_reg == '0);
    assign status.at_end     = end_reg;
    assign status.rd_last    = (CntW'(rd_idx_reg + 1'b1) == count_reg);
    assign status.out_free   = !out_valid_reg || out_ready;

    // Write characters, read one entry per request
    always_ff @(posedge clk)
    begin
        if (cmd.store_char && room)
        begin
            store_mem[count_reg[IdxW-1:0]] <= in_char;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= store_mem[rd_idx_reg[IdxW-1:0]];
        end
    end

    // Label bookkeeping
    always_comb
    begin
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        end_next    = end_reg;
        rd_idx_next = rd_idx_reg;
        if (cmd.store_char)
        begin
            if (room)
            begin
                count_next = count_reg + 1'b1;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        if (cmd.take_delim)
        begin
            end_next = (in_char == CHAR_END);
        end
        if (cmd.load_len)
        begin
            rd_idx_next = '0;
        end
        if (cmd.load_chr)
        begin
            rd_idx_next = rd_idx_reg + 1'b1;
        end
        if (cmd.clear)
        begin
            count_next  = '0;
            ovf_next    = 1'b0;
            rd_idx_next = '0;
        end
    end

    // Output word: load one of three sources, drop the word once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_ovf_next   = out_ovf_reg;
        out_last_next  = out_last_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        priority if (cmd.load_len)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = (end_reg && status.count_zero) ? ZONE_MARK : len_byte;
            out_ovf_next   = ovf_reg;
            out_last_next  = status.count_zero && !end_reg;
        end
        else if (cmd.load_chr)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = rd_data_reg;
            out_ovf_next   = ovf_reg;
            out_last_next  = status.rd_last && !end_reg;
        end
        else if (cmd.load_term)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = CHAR_END;
            out_ovf_next   = ovf_reg;
            out_last_next  = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_next;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            end_reg       <= 1'b0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            end_reg       <= end_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload of the output word
    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_ovf_reg  <= out_ovf_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_ovf   = out_ovf_reg;
    assign out_last  = out_last_reg;

    // The label never holds more than the bound
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CountMax)
        else $error("label count beyond bound");

    // Starting a new label empties the count and the overflow mark
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> (count_reg == '0) && !ovf_reg)
        else $error("label not cleared");

    // An empty final label gives the zone marker
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_len && end_reg && (count_reg == '0) |=> out_byte_reg == ZONE_MARK)
        else $error("zone marker missing");

    // A word is only loaded when the output register has room
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_len || cmd.load_chr || cmd.load_term) |-> status.out_free)
        else $error("output word overwritten");

endmodule

@@ design/dns_name_label_encoder.sv @@
// Top level of the DNS name label encoder.
//
// Channel   Dir  Word                      Accepted when
// s_axis    in   tdata[7:0] name_char      s_axis_tvalid && s_axis_tready
// m_axis    out  tdata[7:0] out_byte,      m_axis_tvalid && m_axis_tready
//                tuser[0] label_overflow,
//                tlast last_of_run
//
// A label character is accepted and written into the label store while it has room.
// A dot or the zero byte starts a flush: the length byte or zone marker, then a store
// read and an output load per character, and the terminator when the name ends.
// The registered store read ahead of each character load sets the flush rate.
// Input is not taken during a flush; output stalls hold the flush in place.
// Reset is asynchronous and empties the label; the store itself is not cleared.
`timescale 1ns / 1ps

module dns_name_label_encoder
    import dnle_pkg::*;
#(
    parameter int LABEL_MAX = LABEL_MAX_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] name_char
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [0:0] m_axis_tuser,   // [0] label_overflow
    output logic       m_axis_tlast
);

    dnle_cmd_t    cmd;
    dnle_status_t status;

    dnle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    dnle_dp #(
        .LABEL_MAX (LABEL_MAX)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_char   (s_axis_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_ovf   (m_axis_tuser[0]),
        .out_last  (m_axis_tlast)
    );

endmodule

@@ tb/dns_name_label_encoder_test.sv @@
// Self-checking testbench for the DNS name label encoder stream block.
`timescale 1ns / 1ps

module dns_name_label_encoder_test;
    import dnle_pkg::*;

    localparam int LBL_MAX     = LABEL_MAX_DEF;
    localparam int ITEM_TARGET = 280;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 20;

    // One encoded output word as the block should present it
    typedef struct {
        logic [7:0] val;
        logic       ovf;
        logic       last;
    } enc_word_t;

    // Directed row: a character sent reps times, with up to two typed results
    typedef struct packed {
        logic [7:0] ch;
        logic [7:0] reps;
        logic [1:0] n_typed;
        logic [7:0] typed0;
        logic [7:0] typed1;
    } dir_row_t;

    localparam int DIR_ROWS = 17;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] name_char
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] out_byte
    logic [0:0] m_axis_tuser;           // [0] label_overflow
    logic       m_axis_tlast;

    // Shadow of the label being gathered
    logic [7:0] label_buf [0:LBL_MAX-1];
    int         label_len = 0;
    logic       label_ovf = 1'b0;

    enc_word_t  enc_q [$];

    int tx_idle_pct = 35;
    int rx_idle_pct = 77;
    int rx_hold_req = 0;
    int errors = 0;
    int items_sent = 0;
    int words_checked = 0;
    int names_sent = 0;
    int labels_sent = 0;
    int long_labels = 0;

    dir_row_t dir_table [0:DIR_ROWS-1] = '{
        '{CHAR_END, 8'd1, 2'd2, ZONE_MARK, CHAR_END},   // empty name after reset
        '{CHAR_DOT, 8'd1, 2'd1, 8'h00, 8'h00},          // empty label between dots
        '{CHAR_DOT, 8'd1, 2'd1, 8'h00, 8'h00},
        '{CHAR_END, 8'd1, 2'd2, ZONE_MARK, CHAR_END},   // name ending in a dot
        '{8'h61,    8'd1, 2'd0, 8'h00, 8'h00},
        '{CHAR_END, 8'd1, 2'd0, 8'h00, 8'h00},
        '{8'hFF,    8'd1, 2'd0, 8'h00, 8'h00},          // character extremes
        '{8'h01,    8'd1, 2'd0, 8'h00, 8'h00},
        '{8'h2F,    8'd1, 2'd0, 8'h00, 8'h00},          // neighbours of the dot
        '{8'h2D,    8'd1, 2'd0, 8'h00, 8'h00},
        '{8'h7F,    8'd1, 2'd0, 8'h00, 8'h00},
        '{8'h80,    8'd1, 2'd0, 8'h00, 8'h00},
        '{CHAR_DOT, 8'd1, 2'd0, 8'h00, 8'h00},
        '{8'h55,    8'd1, 2'd0, 8'h00, 8'h00},
        '{8'hAA,    8'd1, 2'd0, 8'h00, 8'h00},
        '{8'h5A,    8'd61, 2'd0, 8'h00, 8'h00},         // label one past the bound
        '{CHAR_END, 8'd1, 2'd0, 8'h00, 8'h00}           // terminator keeps the flag
    };

    dns_name_label_encoder #(
        .LABEL_MAX (LBL_MAX)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    // Print one mismatch and count it
    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t ns: %s mismatch: got %02h, expected %02h", $time, what, got, want);
        errors++;
    endtask

    // Advance the label shadow by one character and queue the words it releases
    task automatic encode_char(input logic [7:0] ch);
        enc_word_t w;
        if (ch != CHAR_END && ch != CHAR_DOT)
        begin
            if (label_len < LBL_MAX)
            begin
                label_buf[label_len] = ch;
                label_len++;
            end
            else
                label_ovf = 1'b1;
        end
        else
        begin
            w.ovf  = label_ovf;
            w.last = 1'b0;
            w.val  = (ch == CHAR_END && label_len == 0) ? ZONE_MARK : 8'(label_len);
            enc_q.push_back(w);
            for (int i = 0; i < label_len; i++)
            begin
                w.val = label_buf[i];
                enc_q.push_back(w);
            end
            if (ch == CHAR_END)
            begin
                w.val = CHAR_END;
                enc_q.push_back(w);
            end
            enc_q[enc_q.size()-1].last = 1'b1;
            label_len = 0;
            label_ovf = 1'b0;
        end
    endtask

    // Offer one word, with an occasional gap, and hold it until taken
    task automatic send_char(input logic [7:0] ch);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        do @(posedge clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic send_predicted(input logic [7:0] ch);
        send_char(ch);
        encode_char(ch);
    endtask

    // Stop offering and wait for every queued word to come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (enc_q.size() != 0) @(posedge clk);
    endtask

    // Build one random host name: a few labels, mostly short, now and then long
    task automatic send_random_name();
        int nlabels;
        int len;
        int pick;
        logic [7:0] c;
        nlabels = $urandom_range(1, 4);
        for (int l = 0; l < nlabels; l++)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                len = 0;
            else if (pick < 86)
                len = $urandom_range(1, 10);
            else if (pick < 96)
                len = $urandom_range(11, 40);
            else
                len = $urandom_range(LBL_MAX - 4, LBL_MAX + 4);
            if (len > LBL_MAX)
                long_labels++;
            for (int k = 0; k < len; k++)
            begin
                c = 8'($urandom_range(1, 255));
                if (c == CHAR_DOT)
                    c = c + 8'd1;
                send_predicted(c);
            end
            labels_sent++;
            if (l != nlabels - 1)
                send_predicted(CHAR_DOT);
        end
        // Trailing dot leaves an empty last label
        if ($urandom_range(99) < 20)
            send_predicted(CHAR_DOT);
        send_predicted(CHAR_END);
        names_sent++;
    endtask

    // Stimulus: directed table, then three idling phases of random names
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            for (int k = 0; k < dir_table[r].reps; k++)
            begin
                if (dir_table[r].n_typed != 0)
                begin
                    // Label is empty here, so the shadow stays as it is
                    enc_q.push_back('{dir_table[r].typed0, 1'b0,
                                      dir_table[r].n_typed == 2'd1});
                    if (dir_table[r].n_typed == 2'd2)
                        enc_q.push_back('{dir_table[r].typed1, 1'b0, 1'b1});
                    send_char(dir_table[r].ch);
                end
                else
                    send_predicted(dir_table[r].ch);
            end
        end

        while (items_sent < 140)
            send_random_name();
        wait_drained();

        tx_idle_pct = 77;
        rx_idle_pct = 35;
        while (items_sent < 210)
            send_random_name();
        wait_drained();

        // Back-pressure: hold the receiver off while names keep coming
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_req = HOLD_CYCLES;
        send_random_name();
        send_random_name();
        wait_drained();
        while (items_sent < ITEM_TARGET)
            send_random_name();
        wait_drained();

        repeat (SETTLE) @(posedge clk);
        $display("Covered %0d names, %0d labels (%0d over the bound), %0d input words.",
                 names_sent, labels_sent, long_labels, items_sent);
        $display("Checked %0d output words under three idling mixes and a long hold-off.",
                 words_checked);
        if (errors == 0)
            $display("dns_name_label_encoder_test: PASS");
        else
            $display("dns_name_label_encoder_test: FAIL");
        $finish;
    end

    // Receiver: check each accepted word, then choose the next ready level
    initial
    begin : receiver
        enc_word_t want;
        int stall_left;
        stall_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (enc_q.size() == 0)
                    report_mismatch("unexpected word", m_axis_tdata, 8'h00);
                else
                begin
                    want = enc_q.pop_front();
                    if (m_axis_tdata !== want.val)
                        report_mismatch("out_byte", m_axis_tdata, want.val);
                    if (m_axis_tuser[0] !== want.ovf)
                        report_mismatch("label_overflow", {7'd0, m_axis_tuser[0]},
                                        {7'd0, want.ovf});
                    if (m_axis_tlast !== want.last)
                        report_mismatch("last_of_run", {7'd0, m_axis_tlast},
                                        {7'd0, want.last});
                    words_checked++;
                end
            end
            if (rx_hold_req != 0)
            begin
                stall_left  = rx_hold_req;
                rx_hold_req = 0;
            end
            if (stall_left != 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Guard against a hung block
    initial
    begin
        #2_000_000;
        $display("dns_name_label_encoder_test: FAIL");
        $finish;
    end

endmodule

@@ files.f @@
design/dnle_pkg.sv
design/dnle_ctrl.sv
design/dnle_dp.sv
design/dns_name_label_encoder.sv
tb/dns_name_label_encoder_test.sv
